// ===== rtl/b64_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the character classifier for the Base64
// stream decoder.
// ---------------------------------------------------------------------------
package b64_pkg;

    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 11;
    localparam int SYM_W     = 6;
    localparam int ACC_W     = 12;
    localparam int HELD_W    = 3;

    localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = 11'd32;

    // Queue between the front and back parts.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Result kinds.
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    // Character codes of interest.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_D0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_D9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        CLS_SYMBOL,
        CLS_END,
        CLS_SPACE,
        CLS_BAD
    } chr_class_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              start_of_string;
    } src_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [CHAR_W-1:0]  data_byte;
        logic [COUNT_W-1:0] byte_count;
        logic               last;
    } res_t;

    // One classified character as it travels through the queue.
    typedef struct packed {
        chr_class_t       cls;
        logic [SYM_W-1:0] sym;
        logic             start;
    } qent_t;

    // Classify a character and give its six-bit value when it is a symbol.
    function automatic qent_t classify(input logic [CHAR_W-1:0] c, input logic start);
        qent_t e;
        logic [CHAR_W-1:0] d;
        e.start = start;
        e.sym   = '0;
        e.cls   = CLS_BAD;
        if (c == CH_NUL || c == CH_EQ) begin
            e.cls = CLS_END;
        end else if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
            e.cls = CLS_SPACE;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d     = c - CH_UA;
            e.cls = CLS_SYMBOL;
            e.sym = d[SYM_W-1:0];
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d     = c - CH_LA + 8'd26;
            e.cls = CLS_SYMBOL;
            e.sym = d[SYM_W-1:0];
        end else if (c >= CH_D0 && c <= CH_D9) begin
            d     = c - CH_D0 + 8'd52;
            e.cls = CLS_SYMBOL;
            e.sym = d[SYM_W-1:0];
        end else if (c == CH_PLUS) begin
            e.cls = CLS_SYMBOL;
            e.sym = 6'd62;
        end else if (c == CH_SLASH) begin
            e.cls = CLS_SYMBOL;
            e.sym = 6'd63;
        end
        return e;
    endfunction

endpackage

// ===== rtl/b64_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_front
// Accepts characters, classifies them and pushes them into the queue.
// ---------------------------------------------------------------------------
module b64_front (
    input  logic          src_valid,
    input  b64_pkg::src_t src_data,
    output logic          src_stall,
    input  logic          q_full,
    output logic          q_push,
    output b64_pkg::qent_t q_entry
);
    import b64_pkg::*;

    // Whitespace without a start flag changes nothing, so it is
    // accepted and dropped here rather than taking a queue slot.
    always_comb
    begin
        q_entry   = classify(src_data.char_code, src_data.start_of_string);
        src_stall = q_full;
        q_push    = src_valid && !q_full &&
                    !(q_entry.cls == CLS_SPACE && !src_data.start_of_string);
    end

endmodule

// ===== rtl/b64_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_queue
// Short first-in first-out queue of classified characters.
// ---------------------------------------------------------------------------
module b64_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64_pkg::qent_t push_entry,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output b64_pkg::qent_t head
);
    import b64_pkg::*;

    qent_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on push");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

endmodule

// ===== rtl/b64_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_back
// Decoding state, byte assembly and the result register.
// ---------------------------------------------------------------------------
module b64_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [b64_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                         q_not_empty,
    input  b64_pkg::qent_t               q_head,
    output logic                         q_pop,
    output logic                         res_valid,
    input  logic                         res_stall,
    output b64_pkg::res_t                res_data
);
    import b64_pkg::*;

    logic [COUNT_W-1:0] max_bytes_reg;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               fin_reg, fin_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_data_reg, res_data_next;

    logic [ACC_W-1:0]   acc_base, acc_shift;
    logic [HELD_W-1:0]  held_base;
    logic [HELD_W:0]    held_sum;
    logic [COUNT_W-1:0] cnt_base, cnt_inc, limit;
    logic               fin_base;
    logic [CHAR_W-1:0]  byte_sel;

    assign q_pop     = q_not_empty && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        // A start flag clears the string state before the character counts.
        acc_base  = q_head.start ? '0 : acc_reg;
        held_base = q_head.start ? '0 : held_reg;
        cnt_base  = q_head.start ? '0 : cnt_reg;
        fin_base  = q_head.start ? 1'b0 : fin_reg;

        acc_shift = {acc_base[ACC_W-SYM_W-1:0], q_head.sym};
        held_sum  = {1'b0, held_base} + (HELD_W+1)'(SYM_W);
        cnt_inc   = cnt_base + 1'b1;
        limit     = (max_bytes_reg == '0) ? COUNT_W'(1) : max_bytes_reg;

        case (held_sum[HELD_W-1:0])
            3'd0:    byte_sel = acc_shift[7:0];
            3'd2:    byte_sel = acc_shift[9:2];
            3'd4:    byte_sel = acc_shift[11:4];
            default: byte_sel = acc_shift[7:0];
        endcase

        acc_next       = acc_reg;
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;

        if (q_pop) begin
            acc_next       = acc_base;
            held_next      = held_base;
            cnt_next       = cnt_base;
            fin_next       = fin_base;
            res_valid_next = 1'b0;
            res_data_next.kind       = KIND_DONE;
            res_data_next.data_byte  = '0;
            res_data_next.byte_count = cnt_base;
            res_data_next.last       = 1'b1;
            if (!fin_base) begin
                case (q_head.cls)
                    CLS_END:
                    begin
                        fin_next       = 1'b1;
                        res_valid_next = 1'b1;
                    end
                    CLS_BAD:
                    begin
                        fin_next                = 1'b1;
                        res_valid_next          = 1'b1;
                        res_data_next.kind      = KIND_INVALID;
                    end
                    CLS_SYMBOL:
                    begin
                        acc_next = acc_shift;
                        if (held_sum[HELD_W]) begin
                            held_next                = held_sum[HELD_W-1:0];
                            cnt_next                 = cnt_inc;
                            res_valid_next           = 1'b1;
                            res_data_next.kind       = KIND_BYTE;
                            res_data_next.data_byte  = byte_sel;
                            res_data_next.byte_count = cnt_inc;
                            res_data_next.last       = (cnt_inc >= limit);
                            fin_next                 = (cnt_inc >= limit);
                        end else begin
                            held_next = held_sum[HELD_W-1:0];
                        end
                    end
                    default:
                    begin
                        res_valid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_bytes_reg <= MAX_BYTES_RESET;
            acc_reg       <= '0;
            held_reg      <= '0;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_bytes_reg <= cfg_data;
            end
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.kind != KIND_BYTE) |->
        (res_data_reg.last && res_data_reg.data_byte == '0))
        else $error("end result without last flag or with data");

    a_held_even: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg[0])
        else $error("odd number of held bits");

    a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && res_valid_next && res_data_next.last) |=> fin_reg)
        else $error("last result did not finish the string");

endmodule

// ===== rtl/base64_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming Base64 decoder: one character in, at most one result out.
// ---------------------------------------------------------------------------
//
//  Channel  Signals                        Direction  Carries
//  -------  -----------------------------  ---------  -----------------------
//  src      src_valid, src_stall, src_data in         one character, start flag
//  res      res_valid, res_stall, res_data out        byte, done or invalid
//  cfg      cfg_valid, cfg_ready, cfg_data in         max_bytes limit
//
//  One character is taken every cycle while the queue has room; the rate is
//  set by the two-entry queue and the decode step behind it. A character
//  is written into the queue and then decoded into the result register.
//  rst_n clears the queue, the decoding state and the result valid, and
//  restores max_bytes to 32. A stall on the result side holds the result
//  register; the queue then fills and src_stall rises after two more items.
//
// The front classifies each character (end, whitespace, symbol or bad) and
// drops plain whitespace immediately. The queue decouples it from the back,
// which holds the bit accumulator, the byte count and the finished flag, and
// assembles bytes into the result register. Configuration is always ready;
// it is to be written only while the block is idle, which the block does not enforce.
module base64_stream_decoder_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    output logic                        src_stall,
    input  b64_pkg::src_t               src_data,
    output logic                        res_valid,
    input  logic                        res_stall,
    output b64_pkg::res_t               res_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [b64_pkg::COUNT_W-1:0] cfg_data
);
    import b64_pkg::*;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_not_empty;
    qent_t q_entry;
    qent_t q_head;

    // The limit register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    b64_front u_front (
        .src_valid (src_valid),
        .src_data  (src_data),
        .src_stall (src_stall),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    b64_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    b64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data)
    );

endmodule

// ===== bench/base64_stream_decoder_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_decoder_core_test
// Self-checking bench for the streaming Base64 decoder. Characters are fed
// from a queue with random gaps and random back-pressure on the results.
// Every accepted character is run through a behavioural decoder kept in the
// bench, and each result transaction is compared field by field against the
// oldest outstanding prediction.
// ---------------------------------------------------------------------------
module base64_stream_decoder_core_test;

    import b64_pkg::*;

    localparam int          HALF_PERIOD   = 4;
    localparam int          RESET_CYCLES  = 9;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          PHASE_ITEMS   = 160;
    localparam int          HOLD_CYCLES   = 150;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_stall;
    src_t               src_data  = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    res_t               res_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data  = '0;

    base64_stream_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Characters waiting to be offered, and decoded results still owed by
    // the block, oldest first.
    src_t pending_chars[$];
    res_t expected_results[$];

    // Idle rates in percent, and the long result hold used to fill the block.
    int unsigned src_idle_pct  = 0;
    int unsigned res_stall_pct = 0;
    bit          hold_results  = 1'b0;

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    // Bench copy of the decoding state. It mirrors the block after reset:
    // an empty accumulator and an open string, so decoding starts without a
    // start flag. The byte limit follows every register write.
    logic [ACC_W-1:0]   acc_bits    = '0;
    int unsigned        held_bits   = 0;
    logic [COUNT_W-1:0] bytes_out   = '0;
    bit                 string_over = 1'b0;
    logic [COUNT_W-1:0] byte_limit  = MAX_BYTES_RESET;

    res_t predicted;
    res_t oldest;

    // Clock: 8 ns period.
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Watchdog. A run that stalls or loses results ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("base64_stream_decoder_core regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // Sort a character into end marker, whitespace, alphabet symbol or bad
    // character, giving the six-bit value of a symbol.
    function automatic chr_class_t char_class(input logic [CHAR_W-1:0] c,
                                              output logic [SYM_W-1:0] v);
        v = '0;
        if (c == CH_NUL || c == CH_EQ)
            return CLS_END;
        if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
            return CLS_SPACE;
        if (c >= CH_UA && c <= CH_UZ)
        begin
            v = SYM_W'(c - CH_UA);
            return CLS_SYMBOL;
        end
        if (c >= CH_LA && c <= CH_LZ)
        begin
            v = SYM_W'(c - CH_LA + 8'd26);
            return CLS_SYMBOL;
        end
        if (c >= CH_D0 && c <= CH_D9)
        begin
            v = SYM_W'(c - CH_D0 + 8'd52);
            return CLS_SYMBOL;
        end
        if (c == CH_PLUS)
        begin
            v = 6'd62;
            return CLS_SYMBOL;
        end
        if (c == CH_SLASH)
        begin
            v = 6'd63;
            return CLS_SYMBOL;
        end
        return CLS_BAD;
    endfunction

    // Character that encodes a given six-bit value.
    function automatic logic [CHAR_W-1:0] symbol_char(input logic [SYM_W-1:0] v);
        if (v < 26)
            return CH_UA + CHAR_W'(v);
        if (v < 52)
            return CH_LA + CHAR_W'(v - 26);
        if (v < 62)
            return CH_D0 + CHAR_W'(v - 52);
        return (v == 62) ? CH_PLUS : CH_SLASH;
    endfunction

    // Decode one accepted character against the bench state. Returns 1 when
    // the character produces a result, which is then placed in r.
    function automatic bit decode_char(input src_t item, output res_t r);
        logic [SYM_W-1:0]   v;
        chr_class_t         cls;
        logic [COUNT_W-1:0] limit_eff;
        r = '0;
        if (item.start_of_string)
        begin
            acc_bits    = '0;
            held_bits   = 0;
            bytes_out   = '0;
            string_over = 1'b0;
        end
        // A finished string swallows everything until the next start.
        if (string_over)
            return 1'b0;
        cls = char_class(item.char_code, v);
        case (cls)
            CLS_SPACE:
                return 1'b0;
            CLS_END, CLS_BAD:
            begin
                string_over  = 1'b1;
                r.kind       = (cls == CLS_END) ? KIND_DONE : KIND_INVALID;
                r.byte_count = bytes_out;
                r.last       = 1'b1;
                return 1'b1;
            end
            default:
            begin
                acc_bits  = {acc_bits[ACC_W-SYM_W-1:0], v};
                held_bits = held_bits + SYM_W;
                if (held_bits < 8)
                    return 1'b0;
                held_bits = held_bits - 8;
                // A limit of zero behaves as a limit of one. The test is
                // "reached or passed", so a limit lowered below the count
                // already emitted ends the string on its next byte.
                limit_eff    = (byte_limit == '0) ? COUNT_W'(1) : byte_limit;
                bytes_out    = bytes_out + 1'b1;
                r.kind       = KIND_BYTE;
                r.data_byte  = CHAR_W'(acc_bits >> held_bits);
                r.byte_count = bytes_out;
                r.last       = (bytes_out >= limit_eff);
                string_over  = r.last;
                return 1'b1;
            end
        endcase
    endfunction

    // Source driver. At each rising edge it first retires an accepted
    // transaction into the prediction, then decides what to offer next. A
    // stalled offer is held unchanged; otherwise a new character is offered
    // unless a random gap is chosen. Valid never looks at stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_data  <= '0;
        end
        else
        begin
            if (src_valid && !src_stall)
            begin
                if (decode_char(src_data, predicted))
                    expected_results.push_back(predicted);
            end
            if (!(src_valid && src_stall))
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    src_valid <= 1'b1;
                    src_data  <= pending_chars.pop_front();
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Checks every accepted result transaction against the
    // oldest prediction and draws the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result kind %0d byte %0h count %0d",
                                              res_data.kind, res_data.data_byte,
                                              res_data.byte_count));
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (res_data.kind !== oldest.kind)
                        report_mismatch($sformatf("kind: expected %0d, got %0d",
                                                  oldest.kind, res_data.kind));
                    if (res_data.data_byte !== oldest.data_byte)
                        report_mismatch($sformatf("data_byte: expected %02h, got %02h",
                                                  oldest.data_byte, res_data.data_byte));
                    if (res_data.byte_count !== oldest.byte_count)
                        report_mismatch($sformatf("byte_count: expected %0d, got %0d",
                                                  oldest.byte_count, res_data.byte_count));
                    if (res_data.last !== oldest.last)
                        report_mismatch($sformatf("last: expected %0d, got %0d",
                                                  oldest.last, res_data.last));
                end
            end
            res_stall <= hold_results || ($urandom_range(99) < res_stall_pct);
        end
    end

    task automatic push_char(input logic [CHAR_W-1:0] c, input bit start);
        src_t item;
        item.char_code       = c;
        item.start_of_string = start;
        pending_chars.push_back(item);
    endtask

    // Queue a literal string; only its first character may carry the start.
    task automatic push_text(input string s, input bit start_first);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], start_first && i == 0);
    endtask

    // Waits for the source queue to empty and every result to arrive, then
    // lets the pipeline settle so that a character with no result that is
    // still inside the block has finished before the register is touched.
    task automatic wait_until_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_chars.size() != 0 || src_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Configuration write, made only while the block is idle.
    task automatic write_max_bytes(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        byte_limit  = value;
        @(negedge clk);
    endtask

    // Random stimulus. Most of it is well-formed Base64 with random content,
    // sprinkled with whitespace and closed by an equals sign, a NUL, a bad
    // character or nothing at all. The rest is broken strings made of any
    // byte, and single characters with a random start flag.
    task automatic queue_random_items(input int count);
        int               made;
        int               pick;
        int               len;
        logic [SYM_W-1:0] v;
        logic [CHAR_W-1:0] c;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        c = ($urandom_range(5) == 0) ? CH_SPACE
                                                     : CH_TAB + CHAR_W'($urandom_range(4));
                        push_char(c, i == 0 && $urandom_range(1) == 1);
                    end
                    push_char(symbol_char(SYM_W'($urandom_range(63))), i == 0);
                end
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    push_char(CH_EQ, 1'b0);
                end
                else if (pick < 70)
                begin
                    push_char(CH_NUL, 1'b0);
                end
                else if (pick < 85)
                begin
                    do
                        c = CHAR_W'($urandom_range(255));
                    while (char_class(c, v) != CLS_BAD);
                    push_char(c, 1'b0);
                end
                // Otherwise the string stays open until the next start.
                made += len + 1;
            end
            else if (pick < 90)
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    push_char(CHAR_W'($urandom_range(255)), i == 0);
                made += len;
            end
            else
            begin
                push_char(CHAR_W'($urandom_range(255)), $urandom_range(1));
                made++;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. No start flag is given first, as the state after
        // reset is that of a fresh string; whitespace sits between symbols.
        push_text("TW F\tu", 1'b0);
        push_char(CH_CR, 1'b0);
        // Symbols from the top of the alphabet, then an equals sign and ignored input.
        push_text("/+z9", 1'b1);
        push_char(CH_EQ, 1'b0);
        push_char(CH_UA, 1'b0);
        // A NUL that also starts a string, then codes at the top of the
        // byte range, which are not in the alphabet.
        push_char(CH_NUL, 1'b1);
        push_char(8'hFF, 1'b1);
        push_char(8'h80, 1'b1);
        push_text("AA", 1'b0);
        push_text("0\nZ*", 1'b1);
        push_text("QUJD", 1'b1);
        wait_until_drained();

        // Limit lowered below the count already emitted in an open string:
        // the very next byte must be flagged as last.
        write_max_bytes(11'd2);
        push_text("RA", 1'b0);
        wait_until_drained();

        // A zero limit behaves as one.
        write_max_bytes(11'd0);
        push_text("QUJD", 1'b1);
        wait_until_drained();

        // Random phases, each with its own limit and idle pattern.
        write_max_bytes(11'd1024);
        queue_random_items(PHASE_ITEMS);
        wait_until_drained();

        write_max_bytes(11'd1);
        src_idle_pct = 45;
        queue_random_items(PHASE_ITEMS);
        wait_until_drained();

        write_max_bytes(11'd2047);
        src_idle_pct  = 0;
        res_stall_pct = 45;
        queue_random_items(PHASE_ITEMS);
        wait_until_drained();

        write_max_bytes(COUNT_W'($urandom_range(2, 40)));
        src_idle_pct  = 30;
        res_stall_pct = 30;
        queue_random_items(PHASE_ITEMS);
        wait_until_drained();

        // Back-pressure: the result side is held off for a long stretch
        // while the source keeps offering, so the block fills up and has to
        // stall its input. The limit goes back to its reset value.
        write_max_bytes(MAX_BYTES_RESET);
        src_idle_pct  = 0;
        res_stall_pct = 0;
        queue_random_items(60);
        fork
            begin
                hold_results = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
        join_none
        wait_until_drained();

        if (fail_count == 0)
            $display("base64_stream_decoder_core regression: pass");
        else
            $display("base64_stream_decoder_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/b64_pkg.sv
rtl/b64_front.sv
rtl/b64_queue.sv
rtl/b64_back.sv
rtl/base64_stream_decoder_core.sv
bench/base64_stream_decoder_core_test.sv
